// ===== rtl/sorted_tid_list_membership_unit_assert.svh =====
// Assertion macros used by the checker module of the tuple identifier list.
`ifndef SORTED_TID_LIST_MEMBERSHIP_UNIT_ASSERT_SVH
`define SORTED_TID_LIST_MEMBERSHIP_UNIT_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define STLM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tid list check failed");

// Condition that must hold in the cycle after its trigger.
`define STLM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tid list check failed");

`endif

// ===== rtl/stlm_pkg.sv =====
// Shared widths, constants and operation codes of the tuple identifier list.
package stlm_pkg;

   localparam int OPCODE_W = 2;
   localparam int BLK_W    = 32;
   localparam int OFF_W    = 16;
   localparam int KEY_W    = BLK_W + OFF_W;
   localparam int CNT_W    = 13;
   localparam int CNT_MAX  = (2 ** CNT_W) - 1;

   localparam int LIST_DEPTH_DEFAULT = 4096;
   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(4096);

   typedef enum logic [OPCODE_W-1:0] {
      OP_RECORD = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

endpackage

// ===== rtl/sorted_tid_list_membership_unit.sv =====
// Sorted tuple identifier list with append, binary-search lookup and clear.
// The block stores up to LIST_DEPTH 48-bit keys ({block_number, offset}) in one
// single-port-read memory and answers each transfer with exactly one response.
// A record, clear or no-op is answered directly: the response appears the cycle
// after the request transfer. A lookup over n stored entries runs a binary search
// that reads one entry per probe from the memory read port, with at most
// floor(log2 n)+1 probes (13 for 4096 entries), before it loads its response.
// The request side is ready again once the block is idle and the response
// register is empty or being taken. Records beyond min(capacity, LIST_DEPTH)
// are dropped and flagged; lookups give the exact binary-search answer, which is
// only meaningful when records arrive in ascending order. The user must write the
// capacity register via csr_write_enable while idle; the block does not enforce it.
module sorted_tid_list_membership_unit #(
   parameter int LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [stlm_pkg::CNT_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [stlm_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [stlm_pkg::BLK_W-1:0]    req_block_number,
   input  logic [stlm_pkg::OFF_W-1:0]    req_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic                          rsp_dropped,
   output logic [stlm_pkg::CNT_W-1:0]    rsp_entry_count
);
   import stlm_pkg::*;

   localparam int ADDR_W = $clog2(LIST_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CAP =
      CNT_W'((LIST_DEPTH > CNT_MAX) ? CNT_MAX : LIST_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] capacity_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic             rsp_dropped_ff, rsp_dropped_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [KEY_W-1:0] key_mem [LIST_DEPTH];
   logic [KEY_W-1:0] probe_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;

   logic [KEY_W-1:0] req_key;
   logic [CNT_W-1:0] eff_capacity;
   logic             req_xfer;
   logic             load_rsp;
   logic [CNT_W-1:0] next_lo;
   logic [CNT_W-1:0] next_hi;
   logic [CNT_W:0]   mid_sum;

   assign req_key   = {req_block_number, req_offset};
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   // The effective capacity saturates at the memory depth.
   assign eff_capacity = (capacity_ff > DEPTH_CAP) ? DEPTH_CAP : capacity_ff;

   // Next search window after comparing the key with the probed entry.
   always_comb begin
      if (key_ff < probe_ff) begin
         next_lo = lo_ff;
         next_hi = mid_ff;
      end else begin
         next_lo = mid_ff + CNT_W'(1);
         next_hi = hi_ff;
      end
      mid_sum = {1'b0, next_lo} + {1'b0, next_hi};
   end

   // Sequencer: records, clears, no-ops and lookup starts in idle, one probe per cycle in search.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = ADDR_W'(mid_ff);
      wr_en          = 1'b0;
      load_rsp       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               load_rsp       = 1'b1;
               rsp_found_in   = 1'b0;
               rsp_dropped_in = 1'b0;
               case (req_opcode)
                  OP_RECORD: begin
                     if (count_ff < eff_capacity) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_dropped_in = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     key_in = req_key;
                     if (count_ff != '0) begin
                        load_rsp = 1'b0;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = count_ff >> 1;
                        rd_addr  = ADDR_W'(count_ff >> 1);
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (key_ff == probe_ff) begin
               load_rsp       = 1'b1;
               rsp_found_in   = 1'b1;
               rsp_dropped_in = 1'b0;
               state_in       = ST_IDLE;
            end else if (next_lo < next_hi) begin
               lo_in   = next_lo;
               hi_in   = next_hi;
               mid_in  = mid_sum[CNT_W:1];
               rd_addr = ADDR_W'(mid_sum[CNT_W:1]);
            end else begin
               load_rsp       = 1'b1;
               rsp_found_in   = 1'b0;
               rsp_dropped_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_in;
      end
   end

   // State, counters and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
      key_ff         <= key_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Key memory: appends write at the fill count, the search reads one entry a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[ADDR_W'(count_ff)] <= req_key;
      end
      probe_ff <= key_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/stlm_checker.sv =====
// Port-level checker for the tuple identifier list, bound to the top level.
`include "sorted_tid_list_membership_unit_assert.svh"

module stlm_checker #(
   parameter int LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic                          rsp_dropped,
   input logic [stlm_pkg::CNT_W-1:0]    rsp_entry_count
);
   import stlm_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CAP =
      CNT_W'((LIST_DEPTH > CNT_MAX) ? CNT_MAX : LIST_DEPTH);

   // A stalled response keeps its payload until the transfer.
   `STLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_dropped) && $stable(rsp_entry_count))

   // Only one response is ever in flight: no request is taken while one is stuck.
   `STLM_ASSERT_SAME(a_one_outstanding, rsp_valid && !rsp_ready, !req_ready)

   // After a request transfer either its response shows or the block is busy.
   `STLM_ASSERT_NEXT(a_req_progress, req_valid && req_ready, rsp_valid || !req_ready)

   // A response is never both a hit and a drop, and the count stays in range.
   `STLM_ASSERT_SAME(a_rsp_sane, rsp_valid,
      !(rsp_found && rsp_dropped) && (rsp_entry_count <= DEPTH_CAP))

endmodule

bind sorted_tid_list_membership_unit stlm_checker #(.LIST_DEPTH(LIST_DEPTH)) u_stlm_checker (.*);
